// ===== hw/rtl/ppg_pkg.sv =====
// Shared types, widths, register indexes and constants for the PPG heart-rate estimator.
package ppg_pkg;

   localparam int IR_W        = 18;
   localparam int TIME_W      = 32;
   localparam int IVL_W       = 16;
   localparam int RATE_W      = 8;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 3;

   localparam int SMOOTH_DEPTH_DEF   = 8;
   localparam int INTERVAL_DEPTH_DEF = 4;

   localparam int RATE_NUM   = 60000;
   localparam int RATE_NUM_W = 16;
   localparam int BASE_SHIFT = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_FINGER_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_HYSTERESIS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_MIN_MS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_MAX_MS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_LOW_BOUND   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_HIGH_BOUND  = 3'd6;

   typedef struct packed {
      logic [IR_W-1:0]   ir_sample;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_bpm;
      logic              finger_present;
      logic              beat_seen;
   } rsp_type;

   typedef struct packed {
      req_type item;
      logic    finger;
   } q_entry_type;

   typedef struct packed {
      logic [IR_W-1:0]   finger_threshold;
      logic [IR_W-1:0]   peak_threshold;
      logic [IR_W-1:0]   peak_hysteresis;
      logic [IVL_W-1:0]  interval_min_ms;
      logic [IVL_W-1:0]  interval_max_ms;
      logic [RATE_W-1:0] rate_low_bound;
      logic [RATE_W-1:0] rate_high_bound;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      finger_threshold: 18'd50000,
      peak_threshold:   18'd800,
      peak_hysteresis:  18'd300,
      interval_min_ms:  16'd300,
      interval_max_ms:  16'd2000,
      rate_low_bound:   8'd30,
      rate_high_bound:  8'd200
   };

endpackage

// ===== hw/rtl/ppg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ppg_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ppg_div.sv =====
// Iterative restoring divider that retires two quotient bits per cycle.
module ppg_div #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int STEPS = (WIDTH + 1) / 2;
   localparam int DW    = 2 * STEPS;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [DW-1:0]    rem_ff, rem_in;

   logic [DW:0]   r1, r1d, r2, r2d;
   logic          ge1, ge2;
   logic [DW-1:0] dvd1;

   // Two restoring steps per cycle.
   always_comb begin
      r1   = {rem_ff, dvd_ff[DW-1]};
      ge1  = (r1 >= {1'b0, dvs_ff});
      r1d  = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      dvd1 = {dvd_ff[DW-2:0], ge1};
      r2   = {r1d[DW-1:0], dvd1[DW-1]};
      ge2  = (r2 >= {1'b0, dvs_ff});
      r2d  = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         dvd_in  = DW'(dividend);
         dvs_in  = DW'(divisor);
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd1[DW-2:0], ge2};
         rem_in = r2d[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[WIDTH-1:0];

endmodule

// ===== hw/rtl/ppg_queue.sv =====
// Short FIFO that decouples the classifying front from the processing back.
module ppg_queue import ppg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output q_entry_type pop_entry
);

   q_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wptr_ff] <= push_entry;
      end
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = entries_ff[rptr_ff];

endmodule

// ===== hw/rtl/ppg_front.sv =====
// Input stage: takes request beats, tags finger presence and feeds the queue.
module ppg_front import ppg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   input  logic [IR_W-1:0] finger_threshold,
   output logic            push,
   output q_entry_type     push_entry,
   input  logic            q_full
);

   logic        valid_ff, valid_in;
   q_entry_type entry_ff, entry_in;
   logic        accept;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = accept || (valid_ff && q_full);
      entry_in = entry_ff;
      if (accept) begin
         entry_in.item   = req_data;
         entry_in.finger = (req_data.ir_sample > finger_threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push       = valid_ff && !q_full;
   assign push_entry = entry_ff;

endmodule

// ===== hw/rtl/ppg_back.sv =====
// Processing sequencer: smoothing, baseline, peak detection, interval ring and rate.
module ppg_back import ppg_pkg::*; #(
   parameter int SMOOTH_DEPTH   = SMOOTH_DEPTH_DEF,
   parameter int INTERVAL_DEPTH = INTERVAL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  q_entry_type q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int SPOS_W = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
   localparam int IPOS_W = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
   localparam int SSUM_W = IR_W + $clog2(SMOOTH_DEPTH);
   localparam int ISUM_W = IVL_W + $clog2(INTERVAL_DEPTH);
   localparam int DIV_W  = (IVL_W > RATE_NUM_W) ? IVL_W : RATE_NUM_W;
   localparam int BL_W   = IR_W + BASE_SHIFT;
   localparam int AC_W   = IR_W + 2;

   // Dividing a sum by a window depth is a multiply by the rounded-up
   // reciprocal and a shift; the extra shift bits keep it exact for every sum.
   localparam int SREC_SH = SSUM_W + $clog2(SMOOTH_DEPTH);
   localparam int SREC_W  = SSUM_W + 1;
   localparam int SPROD_W = SSUM_W + SREC_W;
   localparam logic [SREC_W-1:0] SREC_M = SREC_W'(((longint'(1) << SREC_SH) +
      longint'(SMOOTH_DEPTH) - 1) / longint'(SMOOTH_DEPTH));
   localparam int IREC_SH = ISUM_W + $clog2(INTERVAL_DEPTH);
   localparam int IREC_W  = ISUM_W + 1;
   localparam int IPROD_W = ISUM_W + IREC_W;
   localparam logic [IREC_W-1:0] IREC_M = IREC_W'(((longint'(1) << IREC_SH) +
      longint'(INTERVAL_DEPTH) - 1) / longint'(INTERVAL_DEPTH));

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_SMEAN = 3'd2;
   localparam logic [2:0] ST_DET   = 3'd3;
   localparam logic [2:0] ST_IMEAN = 3'd4;
   localparam logic [2:0] ST_RATE  = 3'd5;
   localparam logic [2:0] ST_BASE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   req_type             item_ff, item_in;
   logic [SPOS_W-1:0]   spos_ff, spos_in;
   logic                wrapped_ff, wrapped_in;
   logic [SSUM_W-1:0]   ssum_ff, ssum_in;
   logic [IR_W-1:0]     mean_ff, mean_in;
   logic [IR_W-1:0]     baseline_ff, baseline_in;
   logic                armed_ff, armed_in;
   logic [TIME_W-1:0]   prior_ff, prior_in;
   logic [IVL_W-1:0]    ring_ff [INTERVAL_DEPTH];
   logic [IVL_W-1:0]    ring_in [INTERVAL_DEPTH];
   logic [IPOS_W-1:0]   ipos_ff, ipos_in;
   logic [ISUM_W-1:0]   isum_ff, isum_in;
   logic [RATE_W-1:0]   rate_hold_ff, rate_hold_in;
   logic                beat_ff, beat_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic                ram_we;
   logic [IR_W-1:0]     ram_rdata;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend, div_divisor, div_q;
   logic                div_done;
   logic                finish;
   logic [IR_W-1:0]     old_sample;
   logic [SPROD_W-1:0]  sprod;
   logic [IPROD_W-1:0]  iprod;
   logic [IVL_W-1:0]    imean;
   logic [BL_W-1:0]     bl_sum;
   logic signed [AC_W-1:0] ac, pk_lvl, rearm_lvl;
   logic [TIME_W-1:0]   dt;
   logic                in_band;

   ppg_ram #(
      .WIDTH (IR_W),
      .DEPTH (SMOOTH_DEPTH),
      .AW    (SPOS_W)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (spos_ff),
      .wdata (item_ff.ir_sample),
      .raddr (spos_ff),
      .rdata (ram_rdata)
   );

   ppg_div #(
      .WIDTH (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      old_sample = wrapped_ff ? ram_rdata : '0;
      sprod      = SPROD_W'(ssum_ff) * SPROD_W'(SREC_M);
      iprod      = IPROD_W'(isum_ff) * IPROD_W'(IREC_M);
      imean      = iprod[IREC_SH +: IVL_W];
      bl_sum     = {baseline_ff, {BASE_SHIFT{1'b0}}} - BL_W'(baseline_ff) + BL_W'(mean_ff);
      ac         = $signed({2'b00, mean_ff}) - $signed({2'b00, baseline_ff});
      pk_lvl     = $signed({2'b00, cfg.peak_threshold});
      rearm_lvl  = pk_lvl - $signed({2'b00, cfg.peak_hysteresis});
      dt         = item_ff.time_ms - prior_ff;
      in_band    = (dt >= TIME_W'(cfg.interval_min_ms)) && (dt <= TIME_W'(cfg.interval_max_ms));
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      spos_in      = spos_ff;
      wrapped_in   = wrapped_ff;
      ssum_in      = ssum_ff;
      mean_in      = mean_ff;
      baseline_in  = baseline_ff;
      armed_in     = armed_ff;
      prior_in     = prior_ff;
      ring_in      = ring_ff;
      ipos_in      = ipos_ff;
      isum_in      = isum_ff;
      rate_hold_in = rate_hold_ff;
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      finish       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_pop   = 1'b1;
               item_in = q_entry.item;
               beat_in = 1'b0;
               if (!q_entry.finger) begin
                  // No finger: rate drops to zero and everything else freezes.
                  rate_hold_in = '0;
                  out_valid_in = 1'b1;
                  out_data_in  = '0;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            ssum_in      = ssum_ff - SSUM_W'(old_sample) + SSUM_W'(item_ff.ir_sample);
            ram_we       = 1'b1;
            if (spos_ff == SPOS_W'(SMOOTH_DEPTH - 1)) begin
               spos_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               spos_in = spos_ff + 1'b1;
            end
            state_in     = ST_SMEAN;
         end
         ST_SMEAN: begin
            mean_in  = sprod[SREC_SH +: IR_W];
            state_in = ST_BASE;
         end
         ST_BASE: begin
            baseline_in = bl_sum[BL_W-1:BASE_SHIFT];
            state_in    = ST_DET;
         end
         ST_DET: begin
            if (!armed_ff && (ac > pk_lvl)) begin
               armed_in = 1'b1;
               beat_in  = 1'b1;
               prior_in = item_ff.time_ms;
               if (in_band) begin
                  ring_in[ipos_ff] = dt[IVL_W-1:0];
                  isum_in = isum_ff - ISUM_W'(ring_ff[ipos_ff]) + ISUM_W'(dt[IVL_W-1:0]);
                  ipos_in = (ipos_ff == IPOS_W'(INTERVAL_DEPTH - 1)) ? '0 : ipos_ff + 1'b1;
                  state_in     = ST_IMEAN;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               if (armed_ff && (ac < rearm_lvl)) begin
                  armed_in = 1'b0;
               end
               finish = 1'b1;
            end
         end
         ST_IMEAN: begin
            if (imean == '0) begin
               finish = 1'b1;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(RATE_NUM);
               div_divisor  = DIV_W'(imean);
               state_in     = ST_RATE;
            end
         end
         ST_RATE: begin
            if (div_done) begin
               if ((div_q > DIV_W'(cfg.rate_low_bound)) &&
                   (div_q < DIV_W'(cfg.rate_high_bound))) begin
                  rate_hold_in = div_q[RATE_W-1:0];
               end
               finish = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         out_valid_in                = 1'b1;
         out_data_in.rate_bpm        = rate_hold_in;
         out_data_in.finger_present  = 1'b1;
         out_data_in.beat_seen       = beat_in;
         state_in                    = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spos_ff      <= '0;
         wrapped_ff   <= 1'b0;
         ssum_ff      <= '0;
         baseline_ff  <= '0;
         armed_ff     <= 1'b0;
         prior_ff     <= '0;
         ipos_ff      <= '0;
         isum_ff      <= '0;
         rate_hold_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < INTERVAL_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         spos_ff      <= spos_in;
         wrapped_ff   <= wrapped_in;
         ssum_ff      <= ssum_in;
         baseline_ff  <= baseline_in;
         armed_ff     <= armed_in;
         prior_ff     <= prior_in;
         ipos_ff      <= ipos_in;
         isum_ff      <= isum_in;
         rate_hold_ff <= rate_hold_in;
         out_valid_ff <= out_valid_in;
         ring_ff      <= ring_in;
      end
      item_ff     <= item_in;
      mean_ff     <= mean_in;
      beat_ff     <= beat_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hw/rtl/ppg_heart_rate_estimator_core.sv =====
// Top level of the PPG heart-rate estimator: configuration registers and block wiring.
//
// Each request beat on req_data carries one 18-bit infrared sample and a
// millisecond timestamp. Exactly one response beat on rsp_data follows for
// every request, in order, carrying the current rate in beats per minute,
// a finger-present flag and a flag that marks a newly detected rising peak.
// Both channels use valid and stall; a beat moves on an edge where valid is
// high and stall is low. Registers are to be written only while nothing is
// in flight; the block itself does not enforce this. The front stage
// registers and classifies each request and hands it to a two-entry queue,
// so it keeps taking beats while the back end works. Without a finger, the
// back end registers a zero response as it pops the sample. With one, it
// steps through the window sum, mean, baseline and peak detection states,
// and a beat whose interval is in band also runs the ring mean and, unless
// that mean is zero, the radix-4 division of 60000 by it. The back end takes
// one sample at a time and pops the next only once its response is taken.
// Reset is synchronous and clears the configuration to its defaults, the
// filters, the interval ring and the held rate; no clearing pass is needed.
// When the receiver stalls, the response is held, the back end stops taking
// items, and once the queue fills req_stall rises.
module ppg_heart_rate_estimator_core import ppg_pkg::*; #(
   parameter int SMOOTH_DEPTH   = SMOOTH_DEPTH_DEF,
   parameter int INTERVAL_DEPTH = INTERVAL_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_pop, q_valid;
   q_entry_type q_push_entry, q_pop_entry;

   // Registers are to be written only while the block is idle, so the back
   // end sees a stable configuration for every sample it processes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FINGER_THRESHOLD: cfg_in.finger_threshold = csr_wdata[IR_W-1:0];
            CSR_PEAK_THRESHOLD:   cfg_in.peak_threshold   = csr_wdata[IR_W-1:0];
            CSR_PEAK_HYSTERESIS:  cfg_in.peak_hysteresis  = csr_wdata[IR_W-1:0];
            CSR_INTERVAL_MIN_MS:  cfg_in.interval_min_ms  = csr_wdata[IVL_W-1:0];
            CSR_INTERVAL_MAX_MS:  cfg_in.interval_max_ms  = csr_wdata[IVL_W-1:0];
            CSR_RATE_LOW_BOUND:   cfg_in.rate_low_bound   = csr_wdata[RATE_W-1:0];
            CSR_RATE_HIGH_BOUND:  cfg_in.rate_high_bound  = csr_wdata[RATE_W-1:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front stage tags finger presence so the back end can skip the
   // filters for samples without a finger.
   ppg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .finger_threshold (cfg_ff.finger_threshold),
      .push             (q_push),
      .push_entry       (q_push_entry),
      .q_full           (q_full)
   );

   ppg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .pop_entry  (q_pop_entry)
   );

   ppg_back #(
      .SMOOTH_DEPTH   (SMOOTH_DEPTH),
      .INTERVAL_DEPTH (INTERVAL_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A response without a finger always reports a zero rate and no beat.
   a_no_finger_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.finger_present |->
         (rsp_data.rate_bpm == '0) && !rsp_data.beat_seen)
      else $error("response without finger carries a rate or a beat");

   // The front stage never pushes into a full queue.
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into full queue");

   // Right after reset no response is pending and requests are taken.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not clean after reset");

   // The back end only takes an item from a non-empty queue, with no response pending.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && !rsp_valid)
      else $error("pop from empty queue or with a response pending");

endmodule

// ===== test/ppg_heart_rate_estimator_core_test.sv =====
// Self-checking testbench for the PPG heart-rate estimator core.
module ppg_heart_rate_estimator_core_test import ppg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // The predictor keeps its own copy of the filter depths used by the default build.
   localparam int SMOOTH_SLOTS    = 8;
   localparam int INTERVAL_SLOTS  = 4;
   localparam int BPM_NUMERATOR   = 60000;
   // Cycles with no beat on either channel before the run is declared hung.
   localparam int IDLE_LIMIT      = 4000;
   // Length of the long receiver hold-off that backs the block up.
   localparam int HOLD_OFF_CYCLES = 400;
   // Quiet cycles after the last response, well past the worst back-end latency.
   localparam int SETTLE_CYCLES   = 50;
   // The register port is three bits wide, so one index decodes to nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ppg_heart_rate_estimator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state. It starts out as the block does after reset.
   cfg_type settings = '{
      finger_threshold: 18'd50000,
      peak_threshold:   18'd800,
      peak_hysteresis:  18'd300,
      interval_min_ms:  16'd300,
      interval_max_ms:  16'd2000,
      rate_low_bound:   8'd30,
      rate_high_bound:  8'd200
   };
   logic [IR_W-1:0]   smooth_buf [SMOOTH_SLOTS] = '{default: '0};
   int unsigned       smooth_next = 0;
   logic [IR_W-1:0]   dc_level = '0;
   logic              peak_armed = 1'b0;
   logic [TIME_W-1:0] prev_beat_stamp = '0;
   logic [IVL_W-1:0]  interval_buf [INTERVAL_SLOTS] = '{default: '0};
   int unsigned       interval_next = 0;
   logic [RATE_W-1:0] held_rate = '0;

   // Readings predicted for accepted samples, oldest first.
   rsp_type predicted_readings[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;

   // Idle percentages for the two sides, and the request for a long hold-off.
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   bit hold_pending  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Register writes land in the predictor with the same masking as the hardware:
   // narrow registers keep only their low bits, and the spare index is dropped.
   function void apply_setting(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_FINGER_THRESHOLD: settings.finger_threshold = value;
         CSR_PEAK_THRESHOLD:   settings.peak_threshold   = value;
         CSR_PEAK_HYSTERESIS:  settings.peak_hysteresis  = value;
         CSR_INTERVAL_MIN_MS:  settings.interval_min_ms  = value[IVL_W-1:0];
         CSR_INTERVAL_MAX_MS:  settings.interval_max_ms  = value[IVL_W-1:0];
         CSR_RATE_LOW_BOUND:   settings.rate_low_bound   = value[RATE_W-1:0];
         CSR_RATE_HIGH_BOUND:  settings.rate_high_bound  = value[RATE_W-1:0];
         default: ;
      endcase
   endfunction

   // A detected beat measures the time since the previous one. Only an interval
   // inside the band enters the ring, and the rate derived from the ring mean is
   // kept only when it lies strictly between the bounds.
   function automatic void log_interval(logic [TIME_W-1:0] span);
      int unsigned ring_sum;
      int unsigned ring_mean;
      int unsigned bpm;
      if (span < settings.interval_min_ms || span > settings.interval_max_ms) return;
      interval_buf[interval_next] = span[IVL_W-1:0];
      interval_next = (interval_next + 1) % INTERVAL_SLOTS;
      ring_sum = 0;
      foreach (interval_buf[i]) ring_sum += interval_buf[i];
      ring_mean = ring_sum / INTERVAL_SLOTS;
      // An all-zero ring leaves the held rate alone.
      if (ring_mean == 0) return;
      bpm = BPM_NUMERATOR / ring_mean;
      if (bpm > settings.rate_low_bound && bpm < settings.rate_high_bound)
         held_rate = RATE_W'(bpm);
   endfunction

   // Works out the reading for one accepted sample and advances the predictor.
   function automatic rsp_type estimate_rate(req_type sample);
      rsp_type     result;
      int unsigned window_sum;
      int unsigned window_mean;
      int unsigned blend;
      int          ac_level;
      logic        beat;
      result = '0;
      // Without a finger the filters freeze and the rate drops to zero.
      if (sample.ir_sample <= settings.finger_threshold) begin
         held_rate = '0;
         return result;
      end
      smooth_buf[smooth_next] = sample.ir_sample;
      smooth_next = (smooth_next + 1) % SMOOTH_SLOTS;
      window_sum = 0;
      foreach (smooth_buf[i]) window_sum += smooth_buf[i];
      window_mean = window_sum / SMOOTH_SLOTS;
      // The baseline creeps toward the mean by 1/32 of the gap on every sample.
      blend = 32'(dc_level) * 31 + window_mean;
      dc_level = IR_W'(blend / 32);
      ac_level = int'(window_mean) - int'(dc_level);
      // Rising-edge detector: the re-arm level may go negative when the
      // hysteresis exceeds the threshold, so the compare is signed.
      beat = 1'b0;
      if (!peak_armed && ac_level > int'(settings.peak_threshold)) begin
         peak_armed = 1'b1;
         beat = 1'b1;
      end else if (peak_armed &&
                   ac_level < int'(settings.peak_threshold) - int'(settings.peak_hysteresis)) begin
         peak_armed = 1'b0;
      end
      // The interval wraps modulo 2^32 with the timestamp, and the peak time is
      // recorded whether or not the interval is in band.
      if (beat) begin
         log_interval(sample.time_ms - prev_beat_stamp);
         prev_beat_stamp = sample.time_ms;
      end
      result.rate_bpm       = held_rate;
      result.finger_present = 1'b1;
      result.beat_seen      = beat;
      return result;
   endfunction

   function void report_field(string field, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Both channels are sampled at the rising edge, before any of this edge's
   // updates land, so an accepted request is predicted from the payload that
   // was actually taken, and each response beat is checked against the oldest
   // prediction still waiting.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predicted_readings.push_back(estimate_rate(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_readings.size() == 0) begin
               $display("%0t: response beat with nothing expected: %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = predicted_readings.pop_front();
               report_field("rate_bpm", want.rate_bpm, rsp_data.rate_bpm);
               report_field("finger_present", want.finger_present, rsp_data.finger_present);
               report_field("beat_seen", want.beat_seen, rsp_data.beat_seen);
            end
         end
      end
   end

   // Hang detector: any stretch with no beat on either channel that outlasts
   // the longest legitimate stall ends the run as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: stalls at random, and on request holds off for a long stretch
   // so that the queue fills and the block pushes back on its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Offers one sample and waits until it is taken. Valid stays high into the
   // next call unless a random gap is inserted here.
   task automatic send_sample(logic [IR_W-1:0] ir, logic [TIME_W-1:0] stamp);
      req_valid <= 1'b1;
      req_data  <= '{ir_sample: ir, time_ms: stamp};
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Stops offering samples and waits for every predicted reading to come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_setting(index, value);
   endtask

   // Reprograms every register with the block drained. The narrow registers get
   // random junk above their width to show that it is dropped, and a write to
   // the spare index must change nothing.
   task automatic load_settings(logic [CSR_DATA_W-1:0] finger, logic [CSR_DATA_W-1:0] peak,
                                logic [CSR_DATA_W-1:0] hyst, logic [CSR_DATA_W-1:0] ivl_lo,
                                logic [CSR_DATA_W-1:0] ivl_hi, logic [CSR_DATA_W-1:0] bpm_lo,
                                logic [CSR_DATA_W-1:0] bpm_hi);
      wait_idle();
      csr_write(CSR_FINGER_THRESHOLD, finger);
      csr_write(CSR_PEAK_THRESHOLD, peak);
      csr_write(CSR_PEAK_HYSTERESIS, hyst);
      csr_write(CSR_INTERVAL_MIN_MS, {2'($urandom), ivl_lo[IVL_W-1:0]});
      csr_write(CSR_INTERVAL_MAX_MS, {2'($urandom), ivl_hi[IVL_W-1:0]});
      csr_write(CSR_RATE_LOW_BOUND, {10'($urandom), bpm_lo[RATE_W-1:0]});
      csr_write(CSR_RATE_HIGH_BOUND, {10'($urandom), bpm_hi[RATE_W-1:0]});
      csr_write(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // Plausible settings: a finger level below the waveform floor, thresholds
   // that the pulses cross, and bands around the usual human range. The
   // hysteresis sometimes exceeds the threshold.
   task automatic shuffle_settings();
      logic [CSR_DATA_W-1:0] peak;
      peak = CSR_DATA_W'($urandom_range(3000, 100));
      load_settings(CSR_DATA_W'($urandom_range(50000)), peak,
                    CSR_DATA_W'($urandom_range(peak + 500)),
                    CSR_DATA_W'($urandom_range(400, 150)),
                    CSR_DATA_W'($urandom_range(2500, 1200)),
                    CSR_DATA_W'($urandom_range(50, 10)),
                    CSR_DATA_W'($urandom_range(240, 150)));
   endtask

   // A pulse train on a DC level, like a fingertip signal: a pulse of random
   // width every period samples, small noise, timestamps with some jitter and
   // now and then a wrap of the clock, and rare dropouts where the finger lifts.
   task automatic run_waveform(int samples, int unsigned step_max);
      int unsigned       level;
      int unsigned       swing;
      int unsigned       period;
      int unsigned       pulse;
      int unsigned       step;
      logic [TIME_W-1:0] stamp;
      logic [IR_W-1:0]   ir;
      level  = $urandom_range(90000, 60000);
      swing  = $urandom_range(40000, 4000);
      period = $urandom_range(30, 6);
      pulse  = $urandom_range(period / 2, 1);
      step   = $urandom_range(step_max, step_max / 4);
      if ($urandom_range(3) == 0)
         stamp = 32'hFFFF_FFFF - samples * step / 2;
      else
         stamp = $urandom;
      for (int k = 0; k < samples; k++) begin
         ir = IR_W'(level + $urandom_range(255));
         if (k % period < pulse) ir += IR_W'(swing);
         if ($urandom_range(49) == 0) ir = IR_W'($urandom_range(settings.finger_threshold));
         send_sample(ir, stamp);
         stamp += TIME_W'(step + (($urandom_range(3) == 0) ? $urandom_range(step / 4) : 0));
      end
   endtask

   task automatic run_noise(int samples);
      for (int k = 0; k < samples; k++)
         send_sample(IR_W'($urandom), $urandom);
   endtask

   // Field extremes at the reset settings, then a short hand-built sequence:
   // a beat whose interval is zero lands in an all-zero ring, a beat across the
   // timestamp wrap gives a rate too high to publish, and a zero sample with a
   // zero finger level counts as no finger.
   task automatic test_directed();
      send_sample('0, '0);
      send_sample(18'd50000, 32'd10);
      // First beat after reset: the interval from time zero is far out of band.
      send_sample('1, '1);
      load_settings('0, 18'd1000, '0, '0, 18'hFFFF, '0, 18'hFF);
      repeat (SMOOTH_SLOTS) send_sample(18'd1, 32'd5);
      send_sample('1, 32'hFFFF_FFFF);
      repeat (SMOOTH_SLOTS) send_sample(18'd1, 32'd100);
      send_sample('1, 32'h0000_0300);
      send_sample('0, 32'h0000_0400);
   endtask

   task automatic test_waveforms(int runs);
      repeat (runs) begin
         shuffle_settings();
         run_waveform($urandom_range(130, 90), 80);
      end
   endtask

   task automatic test_noise(int samples);
      shuffle_settings();
      run_noise(samples);
   endtask

   // Every register at both ends of its range. First nothing can count as a
   // finger; then every nonzero sample is a finger, any rise is a beat and
   // intervals of a few milliseconds give rates far beyond the bounds; last,
   // beats are impossible, only zero intervals pass and the rate band is empty.
   task automatic test_extremes();
      load_settings('1, '1, '1, '1, '1, '1, '1);
      run_noise(20);
      load_settings('0, '0, '0, '0, '1, '0, '1);
      run_waveform(40, 3);
      load_settings('0, '1, '1, '0, '0, '0, '0);
      run_noise(20);
   endtask

   // The receiver stops for a long time while samples keep coming, so the
   // block has to hold its output, fill its queue and stall its input.
   task automatic test_backpressure();
      shuffle_settings();
      hold_pending = 1'b1;
      run_waveform(40, 80);
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The sender idles a little, the receiver a lot.
      send_idle_pct = 28;
      rcv_idle_pct  = 87;
      test_directed();
      test_waveforms(3);
      test_noise(50);

      // The other way round.
      send_idle_pct = 87;
      rcv_idle_pct  = 28;
      test_extremes();
      test_waveforms(2);
      test_noise(50);

      // Full speed on both sides, with the long hold-off in the middle.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_waveforms(3);
      test_backpressure();
      test_noise(30);

      wait_idle();
      if (mismatch_count == 0 && predicted_readings.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
